[rtl/core/crot_pkg.sv]
// Package for the circle / rectangle overlap test unit.
// Holds field widths, shape and pair-mode codes and the stage 2 to 3 word type.
// No dependencies.
package crot_pkg;

	// Field widths
	localparam int COORD_W = 16;               // signed Q12.4 centre
	localparam int EXT_W   = 14;               // unsigned Q10.4 extent
	localparam int MAG_W   = COORD_W;          // magnitude of a centre difference
	localparam int ESUM_W  = EXT_W + 1;        // sum of two extents
	localparam int SQ_W    = 2 * MAG_W;        // square of a magnitude
	localparam int QSQ_W   = 2 * ESUM_W;       // square of an extent sum
	localparam int DSUM_W  = SQ_W + 1;         // sum of two squares

	// Collider shape codes; the unused code behaves as off
	typedef enum logic [1:0] {
		SHAPE_OFF    = 2'd0,
		SHAPE_CIRCLE = 2'd1,
		SHAPE_RECT   = 2'd2
	} shape_t;

	// Pair test selected by the two shapes
	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_CC   = 2'd1,
		MODE_CR   = 2'd2,
		MODE_RR   = 2'd3
	} mode_t;

	// Word handed from the geometry stages to the square-and-compare stages
	typedef struct packed {
		logic              decided;   // result already known, skip the distance test
		logic              dec_hit;   // result when decided
		logic [MAG_W-1:0]  dx;        // x distance to test
		logic [MAG_W-1:0]  dy;        // y distance to test
		logic [ESUM_W-1:0] q;         // radius to test against
	} sq_req_t;

endpackage

[rtl/core/crot_sqcmp.sv]
// Square-and-compare back end of the overlap test: stage 3 squares, stage 4 compares.
// Depends on crot_pkg (sq_req_t, widths).
module crot_sqcmp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  crot_pkg::sq_req_t req,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit
);
	import crot_pkg::*;

	logic              v_s3, v_s4;
	logic              adv_s3, adv_s4;
	logic              decided_s3, dec_hit_s3;
	logic [SQ_W-1:0]   dxx_s3, dyy_s3;
	logic [QSQ_W-1:0]  qq_s3;
	logic              hit_s4;
	logic [DSUM_W-1:0] dsum;

	// Advance a stage when it is empty or the next one moves
	assign adv_s4   = !v_s4 || !out_stall;
	assign adv_s3   = !v_s3 || adv_s4;
	assign in_stall = !adv_s3;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s3) begin
				v_s3 <= in_valid;
			end
			if (adv_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 3: square the distances and the radius
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			decided_s3 <= req.decided;
			dec_hit_s3 <= req.dec_hit;
			dxx_s3     <= SQ_W'(req.dx) * SQ_W'(req.dx);
			dyy_s3     <= SQ_W'(req.dy) * SQ_W'(req.dy);
			qq_s3      <= QSQ_W'(req.q) * QSQ_W'(req.q);
		end
	end

	// Stage 4: inclusive compare of squared distance with squared radius
	assign dsum = DSUM_W'(dxx_s3) + DSUM_W'(dyy_s3);

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			hit_s4 <= decided_s3 ? dec_hit_s3 : (dsum <= DSUM_W'(qq_s3));
		end
	end

	assign out_valid = v_s4;
	assign hit       = hit_s4;

	// Only stall the upstream side while stage 3 holds a word
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s3)
		else $error("crot_sqcmp: stall raised with stage 3 empty");

	// A held stage 3 word is not dropped
	a_s3_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !adv_s3) |=> v_s3)
		else $error("crot_sqcmp: stage 3 word lost while held");

	// A new result after a taken one must come from a valid stage 3 word
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> (!out_valid || $past(v_s3)))
		else $error("crot_sqcmp: result appeared without a source word");

endmodule

[rtl/core/circle_rect_overlap_test_unit.sv]
// Top level of the circle / rectangle overlap test unit.
// Depends on crot_pkg and crot_sqcmp.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | shape_a/b, centre_a/b x,y, extent_a/b w,h
//  output   | out_valid / out_stall| hit
//
// Four-stage pipeline: one word in per cycle while the output is not stalled; a word
// passes the stage 1, 2, 3 and 4 registers in turn, and out_valid is the stage 4 valid bit.
// Stage 1 takes centre differences, stage 2 runs the range tests, stage 3 squares,
// stage 4 compares; the multipliers of stage 3 set the clock.
// Reset clears the valid bits only; no state survives between words.
// Each stage holds while the next one is full and stalled, so a stall at the
// output backs up stage by stage and empty stages still fill.
module circle_rect_overlap_test_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           shape_a,
	input  logic signed [crot_pkg::COORD_W-1:0]  centre_ax,
	input  logic signed [crot_pkg::COORD_W-1:0]  centre_ay,
	input  logic [crot_pkg::EXT_W-1:0]           extent_aw,
	input  logic [crot_pkg::EXT_W-1:0]           extent_ah,
	input  logic [1:0]                           shape_b,
	input  logic signed [crot_pkg::COORD_W-1:0]  centre_bx,
	input  logic signed [crot_pkg::COORD_W-1:0]  centre_by,
	input  logic [crot_pkg::EXT_W-1:0]           extent_bw,
	input  logic [crot_pkg::EXT_W-1:0]           extent_bh,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 hit
);
	import crot_pkg::*;

	logic                     v_s1, v_s2;
	logic                     adv_s1, adv_s2;
	logic                     back_stall;

	logic signed [COORD_W:0]  diff_x, diff_y;
	logic [COORD_W:0]         abs_x, abs_y;
	mode_t                    mode;
	logic [ESUM_W-1:0]        r_sel, hw_sel, hh_sel;

	mode_t                    mode_s1;
	logic [MAG_W-1:0]         ax_s1, ay_s1;
	logic [ESUM_W-1:0]        r_s1, hw_s1, hh_s1;

	logic [ESUM_W:0]          lim_x, lim_y;
	logic                     far, in_x, in_y;
	sq_req_t                  req_d, req_s2;

	// Advance a stage when it is empty or the next one moves
	assign adv_s2   = !v_s2 || !back_stall;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: centre distance magnitudes
	assign diff_x = {centre_ax[COORD_W-1], centre_ax} - {centre_bx[COORD_W-1], centre_bx};
	assign diff_y = {centre_ay[COORD_W-1], centre_ay} - {centre_by[COORD_W-1], centre_by};
	assign abs_x  = diff_x[COORD_W] ? (COORD_W+1)'(-diff_x) : diff_x;
	assign abs_y  = diff_y[COORD_W] ? (COORD_W+1)'(-diff_y) : diff_y;

	// Stage 1: pick the pair test and route the extents
	always_comb begin
		mode   = MODE_NONE;
		r_sel  = '0;
		hw_sel = '0;
		hh_sel = '0;
		if (shape_a == SHAPE_CIRCLE && shape_b == SHAPE_CIRCLE) begin
			mode  = MODE_CC;
			r_sel = ESUM_W'(extent_aw) + ESUM_W'(extent_bw);
		end else if (shape_a == SHAPE_CIRCLE && shape_b == SHAPE_RECT) begin
			mode   = MODE_CR;
			r_sel  = ESUM_W'(extent_aw);
			hw_sel = ESUM_W'(extent_bw);
			hh_sel = ESUM_W'(extent_bh);
		end else if (shape_a == SHAPE_RECT && shape_b == SHAPE_CIRCLE) begin
			mode   = MODE_CR;
			r_sel  = ESUM_W'(extent_bw);
			hw_sel = ESUM_W'(extent_aw);
			hh_sel = ESUM_W'(extent_ah);
		end else if (shape_a == SHAPE_RECT && shape_b == SHAPE_RECT) begin
			mode   = MODE_RR;
			hw_sel = ESUM_W'(extent_aw) + ESUM_W'(extent_bw);
			hh_sel = ESUM_W'(extent_ah) + ESUM_W'(extent_bh);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mode_s1 <= mode;
			ax_s1   <= abs_x[MAG_W-1:0];
			ay_s1   <= abs_y[MAG_W-1:0];
			r_s1    <= r_sel;
			hw_s1   <= hw_sel;
			hh_s1   <= hh_sel;
		end
	end

	// Stage 2: range tests and corner offsets
	assign lim_x = (ESUM_W+1)'(hw_s1) + (ESUM_W+1)'(r_s1);
	assign lim_y = (ESUM_W+1)'(hh_s1) + (ESUM_W+1)'(r_s1);
	assign far   = (ESUM_W+1 < MAG_W ? MAG_W : ESUM_W+1)'(ax_s1)
	               > (ESUM_W+1 < MAG_W ? MAG_W : ESUM_W+1)'(lim_x)
	            || (ESUM_W+1 < MAG_W ? MAG_W : ESUM_W+1)'(ay_s1)
	               > (ESUM_W+1 < MAG_W ? MAG_W : ESUM_W+1)'(lim_y);
	assign in_x  = ax_s1 <= MAG_W'(hw_s1);
	assign in_y  = ay_s1 <= MAG_W'(hh_s1);

	always_comb begin
		req_d.decided = 1'b1;
		req_d.dec_hit = 1'b0;
		req_d.dx      = ax_s1;
		req_d.dy      = ay_s1;
		req_d.q       = r_s1;
		unique case (mode_s1)
			MODE_NONE: begin
				req_d.decided = 1'b1;
			end
			MODE_CC: begin
				req_d.decided = 1'b0;
			end
			MODE_CR: begin
				if (far) begin
					req_d.dec_hit = 1'b0;
				end else if (in_x || in_y) begin
					req_d.dec_hit = 1'b1;
				end else begin
					req_d.decided = 1'b0;
					req_d.dx      = ax_s1 - MAG_W'(hw_s1);
					req_d.dy      = ay_s1 - MAG_W'(hh_s1);
				end
			end
			MODE_RR: begin
				req_d.dec_hit = in_x && in_y;
			end
			default: begin
				req_d.decided = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			req_s2 <= req_d;
		end
	end

	// Stages 3 and 4
	crot_sqcmp u_sqcmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_stall  (back_stall),
		.req       (req_s2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit)
	);

	// Only stall the input while stage 1 holds a word
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("crot top: input stalled with stage 1 empty");

	// A held stage 1 word keeps its payload
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> (v_s1 && $stable(ax_s1) && $stable(ay_s1)))
		else $error("crot top: stage 1 word changed while held");

	// Pairs without a circle never reach the distance test
	a_no_circle_decided: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (mode_s1 == MODE_NONE || mode_s1 == MODE_RR)) |-> req_d.decided)
		else $error("crot top: rectangle or off pair sent to distance test");

endmodule
